### sv/bqf_pkg.sv
// Shared types and constants for the Q1.31 transposed direct form II biquad.
// No dependencies; used by the interfaces, the sequencer, the MAC and the top level.
`default_nettype none

package bqf_pkg;

    localparam int DATA_W    = 32;
    localparam int ACC_W     = 64;
    localparam int NUM_COEF  = 5;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef enum logic [CFG_IDX_W-1:0] {
        C_B0  = 3'd0,
        C_B1  = 3'd1,
        C_B2  = 3'd2,
        C_FB1 = 3'd3,
        C_FB2 = 3'd4
    } t_coef;

    typedef enum logic [1:0] {
        OPA_X,
        OPA_Y,
        OPA_ACC_HI
    } t_opa;

    typedef enum logic [1:0] {
        BASE_Z1,
        BASE_Z2,
        BASE_ZERO,
        BASE_ACC
    } t_base;

    typedef enum logic [2:0] {
        S_IDLE,
        S_B0,
        S_Y,
        S_B1,
        S_F1,
        S_B2,
        S_F2,
        S_DONE
    } t_state;

    typedef struct packed {
        t_opa  opa;
        t_coef coef;
        logic  acc_en;
        t_base base;
        logic  acc_sub;
        logic  ld_y;
        logic  ld_z1;
        logic  ld_z2;
        logic  in_ready;
        logic  out_load;
    } t_ctrl;

endpackage

`default_nettype wire

### sv/bqf_in_if.sv
// Input sample channel: valid/ready plus one Q1.31 sample.
// Depends on bqf_pkg.
`default_nettype none

interface bqf_in_if;
    import bqf_pkg::*;

    logic  valid;
    logic  ready;
    t_data sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

### sv/bqf_out_if.sv
// Output sample channel: valid/ready plus one filtered Q1.31 sample.
// Depends on bqf_pkg.
`default_nettype none

interface bqf_out_if;
    import bqf_pkg::*;

    logic  valid;
    logic  ready;
    t_data sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

### sv/bqf_cfg_if.sv
// Coefficient write channel: valid/ready, register index and write data.
// Depends on bqf_pkg.
`default_nettype none

interface bqf_cfg_if;
    import bqf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_data                wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

### sv/bqf_mac.sv
// Shared multiply-accumulate unit: registered doubled 32x32 product, then 64-bit add/sub.
// Depends on bqf_pkg.
`default_nettype none

module bqf_mac (
    input  wire logic           i_clk,
    input  wire bqf_pkg::t_data i_a,
    input  wire bqf_pkg::t_data i_b,
    input  wire bqf_pkg::t_acc  i_base,
    input  wire logic           i_sub,
    input  wire logic           i_acc_en,
    output bqf_pkg::t_acc       o_acc
);
    import bqf_pkg::*;

    t_acc r_prod;
    t_acc r_acc;
    t_acc w_mul;

    // Q1.31 x Q1.31 -> Q1.63, doubling wraps mod 2^64
    assign w_mul = t_acc'(i_a) * t_acc'(i_b);

    always_ff @(posedge i_clk) begin
        r_prod <= {w_mul[ACC_W-2:0], 1'b0};
        if (i_acc_en) begin
            r_acc <= i_sub ? (i_base - r_prod) : (i_base + r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

### sv/bqf_seq.sv
// Sequencer stepping the shared MAC through the five products of one sample.
// Depends on bqf_pkg.
`default_nettype none

module bqf_seq (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_out_free,
    output bqf_pkg::t_ctrl  o_ctrl
);
    import bqf_pkg::*;

    t_state r_state;
    t_state n_state;
    t_ctrl  w_ctrl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_B0;
            end
            S_B0:   n_state = S_Y;
            S_Y:    n_state = S_B1;
            S_B1:   n_state = S_F1;
            S_F1:   n_state = S_B2;
            S_B2:   n_state = S_F2;
            S_F2:   n_state = S_DONE;
            S_DONE: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ctrl          = '0;
        w_ctrl.opa      = OPA_X;
        w_ctrl.coef     = C_B0;
        w_ctrl.base     = BASE_ACC;
        unique case (r_state)
            S_IDLE: begin
                w_ctrl.in_ready = 1'b1;
            end
            S_B0: begin
                w_ctrl.coef = C_B0;
            end
            S_Y: begin
                w_ctrl.coef   = C_B1;
                w_ctrl.acc_en = 1'b1;
                w_ctrl.base   = BASE_Z1;
            end
            S_B1: begin
                // y is the top half of the accumulator right now
                w_ctrl.opa    = OPA_ACC_HI;
                w_ctrl.coef   = C_FB1;
                w_ctrl.acc_en = 1'b1;
                w_ctrl.base   = BASE_Z2;
                w_ctrl.ld_y   = 1'b1;
            end
            S_F1: begin
                w_ctrl.coef    = C_B2;
                w_ctrl.acc_en  = 1'b1;
                w_ctrl.acc_sub = 1'b1;
            end
            S_B2: begin
                w_ctrl.opa    = OPA_Y;
                w_ctrl.coef   = C_FB2;
                w_ctrl.acc_en = 1'b1;
                w_ctrl.base   = BASE_ZERO;
                w_ctrl.ld_z1  = 1'b1;
            end
            S_F2: begin
                w_ctrl.acc_en  = 1'b1;
                w_ctrl.acc_sub = 1'b1;
            end
            S_DONE: begin
                w_ctrl.ld_z2    = 1'b1;
                w_ctrl.out_load = i_out_free;
            end
            default: begin
                w_ctrl.in_ready = 1'b0;
            end
        endcase
    end

    assign o_ctrl = w_ctrl;

endmodule

`default_nettype wire

### sv/biquad_tdf2_q31_filter_top.sv
// Top level of the Q1.31 biquad section: coefficient registers, delay state, output register.
// Depends on bqf_pkg, bqf_in_if, bqf_out_if, bqf_cfg_if, bqf_seq and bqf_mac.
//
//  channel    | port       | direction | payload
//  -----------+------------+-----------+--------------------------
//  sample in  | i_smp_in   | sink      | sample_in  (Q1.31)
//  sample out | o_smp_out  | source    | sample_out (Q1.31)
//  coef write | i_cfg      | sink      | index, wdata (Q1.31)
//
// One sample passes through an accept step, six steps in which one shared 32x32 MAC forms
// the five products, and a finishing step. The result is loaded into the output register
// in the finishing step.
// Ready is high only while the sequencer is idle; cfg ready is always high.
// A pending result waits in the output register; the next sample may be taken meanwhile,
// but the sequencer holds in its final step until the output register is free.
// Synchronous active-low reset clears coefficients, delay state and the output valid flag.
`default_nettype none

module biquad_tdf2_q31_filter_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bqf_in_if.sink    i_smp_in,
    bqf_out_if.source o_smp_out,
    bqf_cfg_if.sink   i_cfg
);
    import bqf_pkg::*;

    t_data r_coef [NUM_COEF];
    t_data r_x;
    t_data r_y;
    t_acc  r_z1;
    t_acc  r_z2;
    t_data r_out_data;
    logic  r_out_valid;

    t_ctrl w_ctrl;
    t_data w_mul_a;
    t_data w_mul_b;
    t_acc  w_base;
    t_acc  w_acc;
    logic  w_out_free;
    logic  w_in_acc;
    logic  w_cfg_wr;

    assign w_in_acc   = i_smp_in.valid && w_ctrl.in_ready;
    assign w_out_free = !r_out_valid || o_smp_out.ready;
    assign w_cfg_wr   = i_cfg.valid && i_cfg.ready
                        && (i_cfg.index < CFG_IDX_W'(NUM_COEF));

    assign i_cfg.ready    = 1'b1;
    assign i_smp_in.ready = w_ctrl.in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (w_cfg_wr) begin
            r_coef[i_cfg.index] <= i_cfg.wdata;
        end
    end

    bqf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp_in.valid),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    always_comb begin
        unique case (w_ctrl.opa)
            OPA_X:      w_mul_a = r_x;
            OPA_Y:      w_mul_a = r_y;
            OPA_ACC_HI: w_mul_a = w_acc[ACC_W-1:ACC_W-DATA_W];
            default:    w_mul_a = r_x;
        endcase
    end

    assign w_mul_b = r_coef[w_ctrl.coef];

    always_comb begin
        unique case (w_ctrl.base)
            BASE_Z1:   w_base = r_z1;
            BASE_Z2:   w_base = r_z2;
            BASE_ZERO: w_base = '0;
            BASE_ACC:  w_base = w_acc;
            default:   w_base = w_acc;
        endcase
    end

    bqf_mac u_mac (
        .i_clk    (i_clk),
        .i_a      (w_mul_a),
        .i_b      (w_mul_b),
        .i_base   (w_base),
        .i_sub    (w_ctrl.acc_sub),
        .i_acc_en (w_ctrl.acc_en),
        .o_acc    (w_acc)
    );

    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_x <= i_smp_in.sample_in;
        if (w_ctrl.ld_y) r_y <= w_acc[ACC_W-1:ACC_W-DATA_W];
        if (w_ctrl.out_load) r_out_data <= r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_z1        <= '0;
            r_z2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ctrl.ld_z1) r_z1 <= w_acc;
            if (w_ctrl.ld_z2) r_z2 <= w_acc;
            if (w_ctrl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_smp_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_smp_out.valid      = r_out_valid;
    assign o_smp_out.sample_out = r_out_data;

endmodule

`default_nettype wire

### sv/bqf_checker.sv
// Port-level checks for the biquad top level, attached by bind.
// Depends on bqf_pkg and biquad_tdf2_q31_filter_top.
`default_nettype none

module bqf_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           i_in_ready,
    input wire logic           i_out_valid,
    input wire logic           i_out_ready,
    input wire bqf_pkg::t_data i_out_data,
    input wire logic           i_cfg_ready
);
    import bqf_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result dropped or changed while stalled");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !i_in_ready ##1 !i_in_ready)
        else $error("new request taken while sample still in work");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !$rose(i_out_valid) ##1 !$rose(i_out_valid))
        else $error("result appeared before the sample was processed");

    a_cfg_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> i_cfg_ready)
        else $error("coefficient port not ready");

endmodule

bind biquad_tdf2_q31_filter_top bqf_checker u_bqf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp_in.valid),
    .i_in_ready  (i_smp_in.ready),
    .i_out_valid (o_smp_out.valid),
    .i_out_ready (o_smp_out.ready),
    .i_out_data  (o_smp_out.sample_out),
    .i_cfg_ready (i_cfg.ready)
);

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for biquad_tdf2_q31_filter_top: a bit-exact Q1.31 biquad predictor
// checks every output sample under random gaps, back-pressure and coefficient changes.
// Depends on bqf_pkg, bqf_in_if, bqf_out_if, bqf_cfg_if and the filter top level.
`timescale 1ns / 100ps

module tb_top;
    import bqf_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam logic [CFG_IDX_W-1:0] IDX_TOP = '1;

    logic i_clk;
    logic i_rst_n;

    bqf_in_if  smp_if ();
    bqf_out_if res_if ();
    bqf_cfg_if cfg_if ();

    biquad_tdf2_q31_filter_top uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_smp_in  (smp_if),
        .o_smp_out (res_if),
        .i_cfg     (cfg_if)
    );

    t_data coef_set [NUM_COEF];
    t_acc  z_first;
    t_acc  z_second;
    t_data expected_samples [$];

    int    err_count;
    int    cycle_count;
    int    hold_off;
    bit    no_idle;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // doubled full-width product, wraps modulo 2^64
    function automatic t_acc q31_product2(input t_data a, input t_data b);
        t_acc wide_a;
        t_acc wide_b;
        wide_a = a;
        wide_b = b;
        return (wide_a * wide_b) << 1;
    endfunction

    function automatic t_data filter_sample(input t_data x);
        t_acc  acc;
        t_data y;
        acc      = z_first + q31_product2(x, coef_set[C_B0]);
        y        = acc[ACC_W-1:DATA_W];
        z_first  = z_second + q31_product2(x, coef_set[C_B1])
                   - q31_product2(y, coef_set[C_FB1]);
        z_second = q31_product2(x, coef_set[C_B2]) - q31_product2(y, coef_set[C_FB2]);
        return y;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_data rand_q31();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3, 4: return t_data'($urandom_range(0, 4095)) - 32'sd2048;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input t_data got, input t_data want);
        $display("[%0t] %s: got %h expected %h", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("biquad_tdf2_q31_filter_top: mismatch");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("sample_out with no request pending", res_if.sample_out, '0);
            end else if (res_if.sample_out !== expected_samples[0]) begin
                report_mismatch("sample_out", res_if.sample_out, expected_samples[0]);
                void'(expected_samples.pop_front());
            end else begin
                void'(expected_samples.pop_front());
            end
        end
    end

    // output side: random stalls plus an optional long hold-off
    initial begin : res_sink
        int stall;
        stall = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                res_if.ready = 1'b0;
            end else if (hold_off > 0) begin
                res_if.ready = 1'b0;
                hold_off--;
            end else if (stall > 0) begin
                res_if.ready = 1'b0;
                stall--;
            end else begin
                res_if.ready = 1'b1;
                if (!no_idle) stall = pick_gap();
            end
        end
    end

    task automatic send_sample(input t_data s);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            smp_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp_if.valid     = 1'b1;
        smp_if.sample_in = s;
        do @(posedge i_clk); while (!smp_if.ready);
        expected_samples.push_back(filter_sample(s));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        smp_if.valid = 1'b0;
        while (expected_samples.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input t_data value);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.wdata = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx < NUM_COEF) coef_set[idx] = value;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_coefs(input t_data b0, input t_data b1, input t_data b2,
                             input t_data f1, input t_data f2);
        write_coef(C_B0, b0);
        write_coef(C_B1, b1);
        write_coef(C_B2, b2);
        write_coef(C_FB1, f1);
        write_coef(C_FB2, f2);
    endtask

    task automatic test_reset_state();
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        wait_idle();
    endtask

    task automatic test_extremes();
        set_coefs(32'sh7FFF_FFFF, '0, '0, '0, '0);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample('0);
        send_sample(32'sd1);
        send_sample(-32'sd1);
        wait_idle();
        // minus one squared: 2^62 doubles into the sign bit
        set_coefs(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '0, '0);
        send_sample(32'sh8000_0000);
        send_sample(32'sh8000_0000);
        send_sample(32'sh8000_0000);
        wait_idle();
    endtask

    task automatic test_acc_wrap();
        set_coefs(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh5555_5555);
        wait_idle();
    endtask

    task automatic test_unused_index();
        for (int i = NUM_COEF; i <= IDX_TOP; i++) write_coef(CFG_IDX_W'(i), $urandom);
        send_sample(32'sh4000_0000);
        send_sample(32'shC000_0000);
        send_sample(32'sh2AAA_AAAA);
        wait_idle();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: set_coefs(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                             32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
                1: set_coefs(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                             32'sh8000_0000, 32'sh8000_0000);
                default: set_coefs(rand_q31(), rand_q31(), rand_q31(), rand_q31(), rand_q31());
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) send_sample(rand_q31());
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        hold_off = 400;
        for (int n = 0; n < 40; n++) send_sample(rand_q31());
        wait_idle();
    endtask

    task automatic test_no_idle();
        no_idle = 1'b1;
        for (int n = 0; n < 100; n++) send_sample($urandom);
        wait_idle();
        no_idle = 1'b0;
    endtask

    task automatic test_pause_until_drained();
        for (int n = 0; n < 10; n++) send_sample(rand_q31());
        @(negedge i_clk);
        smp_if.valid = 1'b0;
        while (expected_samples.size() != 0) @(negedge i_clk);
        for (int n = 0; n < 10; n++) send_sample(rand_q31());
        wait_idle();
    endtask

    initial begin
        err_count        = 0;
        cycle_count      = 0;
        hold_off         = 0;
        no_idle          = 1'b0;
        z_first          = '0;
        z_second         = '0;
        for (int i = 0; i < NUM_COEF; i++) coef_set[i] = '0;
        i_rst_n          = 1'b0;
        smp_if.valid     = 1'b0;
        smp_if.sample_in = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.wdata     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_extremes();
        test_acc_wrap();
        test_unused_index();
        test_random_phases();
        test_backpressure();
        test_no_idle();
        test_pause_until_drained();

        if (expected_samples.size() != 0)
            report_mismatch("requests left without a result", '0, expected_samples[0]);
        if (err_count == 0) begin
            $display("biquad_tdf2_q31_filter_top: match");
        end else begin
            $display("biquad_tdf2_q31_filter_top: mismatch");
        end
        $finish;
    end
endmodule
